// ----- rtl/heat_stencil_7pt_3d_step_unit_assert.svh -----
// Assertion macros for the 3-D heat stencil step unit.
// Used by the port checker; needs nothing else.
`ifndef HEAT_STENCIL_7PT_3D_STEP_UNIT_ASSERT_SVH
`define HEAT_STENCIL_7PT_3D_STEP_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define HS7_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hs7 port check failed");

// next-cycle implication, off while in reset
`define HS7_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hs7 port check failed");

// next-cycle implication, checked through reset as well
`define HS7_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hs7 port check failed");

`endif

// ----- rtl/hs7_pkg.sv -----
// Shared constants, types and helpers for the 3-D heat stencil step unit.
// No dependencies.
`timescale 1ns / 1ps

package hs7_pkg;

    localparam int CELL_W      = 32;
    localparam int VALUE_BITS  = 32;
    localparam int MAX_X_DEF   = 64;
    localparam int MAX_Y_DEF   = 64;
    localparam int GRID_MIN    = 3;
    localparam int GRID_DEF    = 64;
    localparam int GZ_LIMIT    = 4096;
    localparam int PLANE_W     = 12;
    localparam int GRID_XY_W   = 7;
    localparam int GRID_Z_W    = 13;
    localparam int COEF_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [COEF_W-1:0] COEF_DEF = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_X = 3'd0,
        CFG_GRID_Y = 3'd1,
        CFG_GRID_Z = 3'd2,
        CFG_COEF_X = 3'd3,
        CFG_COEF_Y = 3'd4,
        CFG_COEF_Z = 3'd5
    } t_cfg_idx;

    // one memory word: [parity lane][plane slot]
    typedef logic [1:0][1:0][CELL_W-1:0] t_quad;

    // size clamped to GRID_MIN..hi, returned as last index
    function automatic int clamp_last(input int v, input int hi);
        int r;
        begin
            if (v < GRID_MIN) begin
                r = GRID_MIN;
            end else if (v > hi) begin
                r = hi;
            end else begin
                r = v;
            end
            return r - 1;
        end
    endfunction

endpackage

// ----- rtl/heat_stencil_7pt_3d_step_unit.sv -----
// Top level of the 3-D heat equation 7-point stencil step unit.
// Depends on hs7_pkg.
`timescale 1ns / 1ps

// Grid cells enter on the s_axis channel in raster order (x fastest), one
// cell per item: tdata = cell_value (Q8.24), tuser = sweep_start, which
// marks cell (0,0,0) and clears the position counters. When cell (i,j,k)
// enters, the updated value of cell (i,j,k-1) leaves on m_axis: tdata =
// new_value, tlast = last cell of the sweep (plane grid_z-2). The last
// plane gives no results; plane 0 and edge cells in x or y pass through.
// Sizes and gains are written on the cfg channel, which is always ready.
// Throughput is one item per clock: two plane memories, each with one
// write and two read ports, give all six stencil reads of a cell at once.
// A result passes the stages memory read, differences, products, sum and
// output, each registered, on its way from s_axis to m_axis.
// When m_axis stalls the result holds and empty pipeline stages still
// fill; s_axis_tready drops only once all five stages hold results.
// Reset clears the counters and loads the default sizes and gains; the
// plane memories keep contents; a result uses only this sweep's data.
module heat_stencil_7pt_3d_step_unit #(
    parameter int MAX_X = hs7_pkg::MAX_X_DEF,
    parameter int MAX_Y = hs7_pkg::MAX_Y_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [hs7_pkg::CELL_W-1:0]      i_s_axis_tdata,  // [31:0] cell_value
    input  logic                            i_s_axis_tuser,  // [0] sweep_start
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [hs7_pkg::CELL_W-1:0]      o_m_axis_tdata,  // [31:0] new_value
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hs7_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hs7_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int XB   = $clog2(MAX_X);
    localparam int YB   = $clog2(MAX_Y);
    localparam int VA_W = YB - 1 + XB;
    localparam int HA_W = YB + XB - 1;
    localparam int V_DEPTH = 2 ** VA_W;
    localparam int H_DEPTH = 2 ** HA_W;
    localparam int CW   = hs7_pkg::CELL_W;
    localparam int PW_K = hs7_pkg::PLANE_W;
    localparam int DW   = CW + 2;
    localparam int PW   = DW + hs7_pkg::COEF_W + 1;
    localparam int SW   = PW + 2;
    localparam int TW   = SW - 16;
    localparam int RW   = TW + 1;
    localparam int XW   = 65;
    localparam logic signed [SW-1:0] ROUND  = SW'(32768);
    localparam logic signed [XW-1:0] SAT_HI =
        (XW'(1) <<< (hs7_pkg::VALUE_BITS - 1)) - XW'(1);
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

    // configuration
    logic [XB-1:0]                 r_gx_last;
    logic [YB-1:0]                 r_gy_last;
    logic [PW_K-1:0]               r_gz_last;
    logic [hs7_pkg::COEF_W-1:0]    r_coef_x, r_coef_y, r_coef_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gx_last <= XB'(hs7_pkg::clamp_last(hs7_pkg::GRID_DEF, MAX_X));
            r_gy_last <= YB'(hs7_pkg::clamp_last(hs7_pkg::GRID_DEF, MAX_Y));
            r_gz_last <= PW_K'(hs7_pkg::clamp_last(hs7_pkg::GRID_DEF, hs7_pkg::GZ_LIMIT));
            r_coef_x  <= hs7_pkg::COEF_DEF;
            r_coef_y  <= hs7_pkg::COEF_DEF;
            r_coef_z  <= hs7_pkg::COEF_DEF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hs7_pkg::CFG_GRID_X: r_gx_last <= XB'(hs7_pkg::clamp_last(
                    int'(i_cfg_data[hs7_pkg::GRID_XY_W-1:0]), MAX_X));
                hs7_pkg::CFG_GRID_Y: r_gy_last <= YB'(hs7_pkg::clamp_last(
                    int'(i_cfg_data[hs7_pkg::GRID_XY_W-1:0]), MAX_Y));
                hs7_pkg::CFG_GRID_Z: r_gz_last <= PW_K'(hs7_pkg::clamp_last(
                    int'(i_cfg_data[hs7_pkg::GRID_Z_W-1:0]), hs7_pkg::GZ_LIMIT));
                hs7_pkg::CFG_COEF_X: r_coef_x <= i_cfg_data;
                hs7_pkg::CFG_COEF_Y: r_coef_y <= i_cfg_data;
                hs7_pkg::CFG_COEF_Z: r_coef_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_s0_v, r_s1_v, r_s2_v, r_s3_v, r_out_v;
    logic rdy0, rdy1, rdy2, rdy3, rdy_out, acc;

    assign rdy_out = !r_out_v || i_m_axis_tready;
    assign rdy3    = !r_s3_v  || rdy_out;
    assign rdy2    = !r_s2_v  || rdy3;
    assign rdy1    = !r_s1_v  || rdy2;
    assign rdy0    = !r_s0_v  || rdy1;
    assign acc     = i_s_axis_tvalid && rdy0;
    assign o_s_axis_tready = rdy0;

    // position counters
    logic [XB-1:0]   r_col, n_col, col_e;
    logic [YB-1:0]   r_row, n_row, row_e;
    logic [PW_K-1:0] r_plane, n_plane, plane_e;
    logic            x_end, y_end, z_end, emit, inner;

    always_comb begin
        col_e   = i_s_axis_tuser ? '0 : r_col;
        row_e   = i_s_axis_tuser ? '0 : r_row;
        plane_e = i_s_axis_tuser ? '0 : r_plane;
        x_end   = col_e >= r_gx_last;
        y_end   = row_e >= r_gy_last;
        z_end   = plane_e >= r_gz_last;
        emit    = (plane_e != '0) && (plane_e <= r_gz_last);
        inner   = (plane_e[PW_K-1:1] != '0) && (col_e != '0) && (col_e < r_gx_last)
                  && (row_e != '0) && (row_e < r_gy_last);
        n_col   = x_end ? '0 : col_e + 1'b1;
        n_row   = row_e;
        n_plane = plane_e;
        if (x_end) begin
            n_row = y_end ? '0 : row_e + 1'b1;
            if (y_end) begin
                n_plane = z_end ? '0 : plane_e + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else if (acc) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
        end
    end

    // plane memories: V holds row pairs per column, H holds column pairs per row
    logic [YB-2:0]   row_h, row_b;
    logic [XB-2:0]   col_h, col_d;
    logic [VA_W-1:0] va_a, va_b;
    logic [HA_W-1:0] ha_c, ha_d;
    logic            slot;

    assign row_h = row_e[YB-1:1];
    assign row_b = row_e[0] ? row_h + 1'b1 : row_h - 1'b1;
    assign col_h = col_e[XB-1:1];
    assign col_d = col_e[0] ? col_h + 1'b1 : col_h - 1'b1;
    assign va_a  = {row_h, col_e};
    assign va_b  = {row_b, col_e};
    assign ha_c  = {row_e, col_h};
    assign ha_d  = {row_e, col_d};
    assign slot  = plane_e[0];

    hs7_pkg::t_quad r_mem_v [V_DEPTH];
    hs7_pkg::t_quad r_mem_h [H_DEPTH];
    hs7_pkg::t_quad r_rd_a, r_rd_b, r_rd_c, r_rd_d;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_a <= r_mem_v[va_a];
            r_rd_b <= r_mem_v[va_b];
            r_mem_v[va_a][row_e[0]][slot] <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_c <= r_mem_h[ha_c];
            r_rd_d <= r_mem_h[ha_d];
            r_mem_h[ha_c][col_e[0]][slot] <= i_s_axis_tdata;
        end
    end

    // stage registers
    logic signed [CW-1:0] r_s0_u;
    logic                 r_s0_in, r_s0_last, r_s0_rp, r_s0_cp, r_s0_slot;
    logic signed [CW-1:0] r_s1_c;
    logic signed [DW-1:0] r_s1_dx, r_s1_dy, r_s1_dz;
    logic                 r_s1_in, r_s1_last;
    logic signed [CW-1:0] r_s2_c;
    logic signed [PW-1:0] r_s2_px, r_s2_py, r_s2_pz;
    logic                 r_s2_in, r_s2_last;
    logic signed [CW-1:0] r_s3_c;
    logic signed [TW-1:0] r_s3_t;
    logic                 r_s3_in, r_s3_last;
    logic [CW-1:0]        r_out_data;
    logic                 r_out_last;

    // stage 1: pick the stencil taps and form the second differences
    logic                 pv;
    logic signed [CW-1:0] v_c, v_cur, v_up, v_dn, v_l, v_r;
    logic signed [DW-1:0] n_dx, n_dy, n_dz, c2;

    always_comb begin
        pv    = !r_s0_slot;
        v_c   = r_rd_a[r_s0_rp][pv];
        v_cur = r_rd_a[r_s0_rp][r_s0_slot];
        v_up  = r_s0_rp ? r_rd_a[0][pv] : r_rd_b[1][pv];
        v_dn  = r_s0_rp ? r_rd_b[0][pv] : r_rd_a[1][pv];
        v_l   = r_s0_cp ? r_rd_c[0][pv] : r_rd_d[1][pv];
        v_r   = r_s0_cp ? r_rd_d[0][pv] : r_rd_c[1][pv];
        c2    = DW'(v_c) <<< 1;
        n_dx  = DW'(v_r) + DW'(v_l) - c2;
        n_dy  = DW'(v_dn) + DW'(v_up) - c2;
        n_dz  = DW'(r_s0_u) + DW'(v_cur) - c2;
    end

    // stage 2: gains
    logic signed [PW-1:0] n_px, n_py, n_pz;

    assign n_px = PW'(r_s1_dx) * PW'($signed({1'b0, r_coef_x}));
    assign n_py = PW'(r_s1_dy) * PW'($signed({1'b0, r_coef_y}));
    assign n_pz = PW'(r_s1_dz) * PW'($signed({1'b0, r_coef_z}));

    // stage 3: sum, round half up to Q8.24
    logic signed [SW-1:0] sum3;
    logic signed [TW-1:0] n_t;

    assign sum3 = SW'(r_s2_px) + SW'(r_s2_py) + SW'(r_s2_pz) + ROUND;
    assign n_t  = sum3[SW-1:16];

    // output stage: add to center value and saturate, or pass the center value through for edge cells
    logic signed [RW-1:0] rsum;
    logic signed [XW-1:0] wide;
    logic [CW-1:0]        n_out_data;

    always_comb begin
        rsum = RW'(r_s3_c) + RW'(r_s3_t);
        wide = XW'(rsum);
        if (wide > SAT_HI) begin
            wide = SAT_HI;
        end else if (wide < SAT_LO) begin
            wide = SAT_LO;
        end
        n_out_data = r_s3_in ? wide[CW-1:0] : r_s3_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (rdy0) begin
                r_s0_v <= acc && emit;
            end
            if (rdy1) begin
                r_s1_v <= r_s0_v;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (rdy_out) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s0_u    <= i_s_axis_tdata;
            r_s0_in   <= inner;
            r_s0_last <= x_end && y_end && z_end;
            r_s0_rp   <= row_e[0];
            r_s0_cp   <= col_e[0];
            r_s0_slot <= slot;
        end
        if (rdy1) begin
            r_s1_c    <= v_c;
            r_s1_dx   <= n_dx;
            r_s1_dy   <= n_dy;
            r_s1_dz   <= n_dz;
            r_s1_in   <= r_s0_in;
            r_s1_last <= r_s0_last;
        end
        if (rdy2) begin
            r_s2_c    <= r_s1_c;
            r_s2_px   <= n_px;
            r_s2_py   <= n_py;
            r_s2_pz   <= n_pz;
            r_s2_in   <= r_s1_in;
            r_s2_last <= r_s1_last;
        end
        if (rdy3) begin
            r_s3_c    <= r_s2_c;
            r_s3_t    <= n_t;
            r_s3_in   <= r_s2_in;
            r_s3_last <= r_s2_last;
        end
        if (rdy_out) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s3_last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/hs7_checker.sv -----
// Port-level checker for the 3-D heat stencil step unit, bound to the top.
// Depends on hs7_pkg and heat_stencil_7pt_3d_step_unit_assert.svh.
`timescale 1ns / 1ps
`include "heat_stencil_7pt_3d_step_unit_assert.svh"

module hs7_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [hs7_pkg::CELL_W-1:0]  o_m_axis_tdata,  // [31:0] new_value
    input logic                        o_m_axis_tlast
);

    logic out_stall;

    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `HS7_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid)
    `HS7_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_stall,
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
    // input side is free whenever the output register can move
    `HS7_ASSERT_IMP(a_in_free, i_clk, i_rst_n, !out_stall, o_s_axis_tready)
    `HS7_ASSERT_NXT_ALL(a_rst_clear, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind heat_stencil_7pt_3d_step_unit hs7_checker u_hs7_checker (.*);
